// ===== rtl/rgbhsv_pkg.sv =====
// shared widths, stage payload types and hue sector codes for the rgb to hsv pipeline
// no dependencies; imported by every module of the block
`default_nettype none

package rgbhsv_pkg;

    localparam int CHAN_W      = 8;
    localparam int DIFF_W      = CHAN_W + 1;
    localparam int QUO_W       = 8;
    localparam int DIV_STAGES  = QUO_W;
    localparam int SAT_NUM_W   = 2 * CHAN_W;
    localparam int SAT_DEN_W   = CHAN_W;
    localparam int SAT_DSH_W   = SAT_DEN_W + QUO_W - 1;
    localparam int HUE_DEN_W   = CHAN_W + 3;
    localparam int HUE_NUM_W   = HUE_DEN_W + CHAN_W;
    localparam int HUE_DSH_W   = HUE_DEN_W + QUO_W - 1;
    localparam int TDATA_IN_W  = 3 * CHAN_W;
    localparam int TDATA_OUT_W = 3 * CHAN_W;

    typedef enum logic [1:0] {
        BR_RED_GB,
        BR_RED_BG,
        BR_GREEN,
        BR_BLUE
    } branch_t;

    typedef struct packed {
        logic [CHAN_W-1:0] mx;
        logic [CHAN_W-1:0] mn;
        branch_t           branch;
        logic [DIFF_W-1:0] diff;
        logic              frame_end;
    } sel_t;

    typedef struct packed {
        logic [SAT_NUM_W-1:0] sat_num;
        logic [SAT_DSH_W-1:0] sat_dsh;
        logic [HUE_NUM_W-1:0] hue_num;
        logic [HUE_DSH_W-1:0] hue_dsh;
        logic [CHAN_W-1:0]    value;
        logic                 zero;
        logic                 frame_end;
    } prep_t;

    typedef struct packed {
        logic [SAT_NUM_W-1:0] sat_rem;
        logic [SAT_DSH_W-1:0] sat_dsh;
        logic [QUO_W-1:0]     sat_q;
        logic [HUE_NUM_W-1:0] hue_rem;
        logic [HUE_DSH_W-1:0] hue_dsh;
        logic [QUO_W-1:0]     hue_q;
        logic [CHAN_W-1:0]    value;
        logic                 zero;
        logic                 frame_end;
    } div_t;

endpackage

`default_nettype wire

// ===== rtl/rgbhsv_prep.sv =====
// front end: channel max/min and hue sector, then dividends and shifted divisors
// two register stages; uses rgbhsv_pkg
`default_nettype none

module rgbhsv_prep (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [rgbhsv_pkg::CHAN_W-1:0] red,
    input  wire logic [rgbhsv_pkg::CHAN_W-1:0] green,
    input  wire logic [rgbhsv_pkg::CHAN_W-1:0] blue,
    input  wire logic                        frame_end,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output rgbhsv_pkg::prep_t                out_data
);
    import rgbhsv_pkg::*;

    sel_t  a_reg, a_next;
    logic  a_valid_reg;
    prep_t b_reg, b_next;
    logic  b_valid_reg;
    logic  a_en, b_en;

    logic [CHAN_W-1:0]    d;
    logic [HUE_DEN_W-1:0] d11, base, num, den6;
    logic [HUE_NUM_W-1:0] num19;
    logic [SAT_NUM_W-1:0] d16;

    assign b_en     = ~b_valid_reg | out_ready;
    assign a_en     = ~a_valid_reg | b_en;
    assign in_ready = a_en;

    // stage a: max, min, sector and signed channel difference
    always_comb
    begin
        a_next.mx = (red > green) ? ((red > blue) ? red : blue)
                                  : ((green > blue) ? green : blue);
        a_next.mn = (red < green) ? ((red < blue) ? red : blue)
                                  : ((green < blue) ? green : blue);
        if (a_next.mx == red && green >= blue)
            a_next.branch = BR_RED_GB;
        else if (a_next.mx == red)
            a_next.branch = BR_RED_BG;
        else if (a_next.mx == green)
            a_next.branch = BR_GREEN;
        else
            a_next.branch = BR_BLUE;
        unique case (a_next.branch)
            BR_RED_GB, BR_RED_BG: a_next.diff = {1'b0, green} - {1'b0, blue};
            BR_GREEN:             a_next.diff = {1'b0, blue} - {1'b0, red};
            BR_BLUE:              a_next.diff = {1'b0, red} - {1'b0, green};
            default:              a_next.diff = '0;
        endcase
        a_next.frame_end = frame_end;
    end

    // stage b: range, sector offset, times-255 dividends
    always_comb
    begin
        d    = a_reg.mx - a_reg.mn;
        d11  = {{(HUE_DEN_W-CHAN_W){1'b0}}, d};
        den6 = (d11 << 2) + (d11 << 1);
        unique case (a_reg.branch)
            BR_RED_GB: base = '0;
            BR_RED_BG: base = den6;
            BR_GREEN:  base = d11 << 1;
            BR_BLUE:   base = d11 << 2;
            default:   base = '0;
        endcase
        num   = base + {{(HUE_DEN_W-DIFF_W){a_reg.diff[DIFF_W-1]}}, a_reg.diff};
        num19 = {{(HUE_NUM_W-HUE_DEN_W){1'b0}}, num};
        d16   = {{(SAT_NUM_W-CHAN_W){1'b0}}, d};

        b_next.sat_num   = (d16 << CHAN_W) - d16;
        b_next.sat_dsh   = {a_reg.mx, {(QUO_W-1){1'b0}}};
        b_next.hue_num   = (num19 << CHAN_W) - num19;
        b_next.hue_dsh   = {den6, {(QUO_W-1){1'b0}}};
        b_next.value     = a_reg.mx;
        b_next.zero      = (d == '0);
        b_next.frame_end = a_reg.frame_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_en)
                a_valid_reg <= in_valid;
            if (b_en)
                b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_en)
            a_reg <= a_next;
        if (b_en)
            b_reg <= b_next;
    end

    assign out_valid = b_valid_reg;
    assign out_data  = b_reg;

endmodule

`default_nettype wire

// ===== rtl/rgbhsv_div.sv =====
// pipelined restoring divider, one quotient bit per stage, saturation and hue side by side
// uses rgbhsv_pkg
`default_nettype none

module rgbhsv_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire rgbhsv_pkg::prep_t in_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output rgbhsv_pkg::div_t out_data
);
    import rgbhsv_pkg::*;

    localparam int LAST = DIV_STAGES - 1;

    div_t stg_reg   [DIV_STAGES];
    logic valid_reg [DIV_STAGES];
    logic [DIV_STAGES:0] rdy;

    assign rdy[DIV_STAGES] = out_ready;

    genvar k;
    generate
        for (k = 0; k < DIV_STAGES; k++)
        begin : g_stage
            div_t src, stg_next;
            logic src_valid;
            logic sat_ge, hue_ge;

            assign rdy[k] = ~valid_reg[k] | rdy[k+1];

            if (k == 0)
            begin : g_first
                always_comb
                begin
                    src_valid     = in_valid;
                    src.sat_rem   = in_data.sat_num;
                    src.sat_dsh   = in_data.sat_dsh;
                    src.sat_q     = '0;
                    src.hue_rem   = in_data.hue_num;
                    src.hue_dsh   = in_data.hue_dsh;
                    src.hue_q     = '0;
                    src.value     = in_data.value;
                    src.zero      = in_data.zero;
                    src.frame_end = in_data.frame_end;
                end
            end
            else
            begin : g_next
                always_comb
                begin
                    src_valid   = valid_reg[k-1];
                    src         = stg_reg[k-1];
                    src.sat_dsh = stg_reg[k-1].sat_dsh >> 1;
                    src.hue_dsh = stg_reg[k-1].hue_dsh >> 1;
                end
            end

            always_comb
            begin
                stg_next = src;
                sat_ge   = src.sat_rem >= SAT_NUM_W'(src.sat_dsh);
                hue_ge   = src.hue_rem >= HUE_NUM_W'(src.hue_dsh);
                if (sat_ge)
                    stg_next.sat_rem = src.sat_rem - SAT_NUM_W'(src.sat_dsh);
                if (hue_ge)
                    stg_next.hue_rem = src.hue_rem - HUE_NUM_W'(src.hue_dsh);
                stg_next.sat_q = {src.sat_q[QUO_W-2:0], sat_ge};
                stg_next.hue_q = {src.hue_q[QUO_W-2:0], hue_ge};
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[k] <= 1'b0;
                else if (rdy[k])
                    valid_reg[k] <= src_valid;
            end

            always_ff @(posedge clk)
            begin
                if (rdy[k])
                    stg_reg[k] <= stg_next;
            end
        end
    endgenerate

    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[LAST];
    assign out_data  = stg_reg[LAST];

`ifndef NO_ASSERTIONS
    // final remainders must be below the unshifted divisors
    a_sat_rem: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[LAST] && !stg_reg[LAST].zero
        |-> stg_reg[LAST].sat_rem < SAT_NUM_W'(stg_reg[LAST].sat_dsh))
        else $error("saturation remainder not below divisor");

    a_hue_rem: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[LAST] && !stg_reg[LAST].zero
        |-> stg_reg[LAST].hue_rem < HUE_NUM_W'(stg_reg[LAST].hue_dsh))
        else $error("hue remainder not below divisor");

    a_black_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[LAST] && (stg_reg[LAST].value == '0) |-> stg_reg[LAST].zero)
        else $error("black pixel not flagged as gray");
`endif

endmodule

`default_nettype wire

// ===== rtl/rgb_to_hsv_pixel_top.sv =====
// rgb to hsv conversion, one pixel per transfer, 8-bit channels in and out
// 11 register stages: 2 front-end, 8 divider, 1 output, the first loaded at the input
// transfer; one pixel per cycle while m_tready is not held low
// per-stage valid bits with a ready chain, so bubbles close up under stall
// rst_n clears all valid bits asynchronously; data registers are not reset
// uses rgbhsv_pkg, rgbhsv_prep, rgbhsv_div
`default_nettype none

module rgb_to_hsv_pixel_top (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // red [7:0], green [15:8], blue [23:16]
    input  wire logic [rgbhsv_pkg::TDATA_IN_W-1:0]  s_tdata,
    input  wire logic                               s_tlast,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // hue [7:0], saturation [15:8], value [23:16]
    output logic [rgbhsv_pkg::TDATA_OUT_W-1:0]      m_tdata,
    output logic                                    m_tlast
);
    import rgbhsv_pkg::*;

    logic  prep_valid, prep_ready;
    prep_t prep_data;
    logic  div_valid, div_ready;
    div_t  div_data;

    logic              out_valid_reg;
    logic [CHAN_W-1:0] hue_reg, sat_reg, val_reg;
    logic              last_reg;
    logic              o_en;

    rgbhsv_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .red       (s_tdata[CHAN_W-1:0]),
        .green     (s_tdata[2*CHAN_W-1:CHAN_W]),
        .blue      (s_tdata[3*CHAN_W-1:2*CHAN_W]),
        .frame_end (s_tlast),
        .out_valid (prep_valid),
        .out_ready (prep_ready),
        .out_data  (prep_data)
    );

    rgbhsv_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prep_valid),
        .in_ready  (prep_ready),
        .in_data   (prep_data),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_data  (div_data)
    );

    assign o_en      = ~out_valid_reg | m_tready;
    assign div_ready = o_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (o_en)
            out_valid_reg <= div_valid;
    end

    // gray and black pixels force hue and saturation to zero
    always_ff @(posedge clk)
    begin
        if (o_en)
        begin
            hue_reg  <= div_data.zero ? '0 : div_data.hue_q;
            sat_reg  <= div_data.zero ? '0 : div_data.sat_q;
            val_reg  <= div_data.value;
            last_reg <= div_data.frame_end;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {val_reg, sat_reg, hue_reg};
    assign m_tlast  = last_reg;

`ifndef NO_ASSERTIONS
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty pipeline output");

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[CHAN_W-1:0] != '1))
        else $error("hue out of range");

    a_black_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[3*CHAN_W-1:2*CHAN_W] == '0)
        |-> (m_tdata[2*CHAN_W-1:0] == '0))
        else $error("black pixel with nonzero hue or saturation");
`endif

endmodule

`default_nettype wire
